### rtl/psk_pulse_shaping_modulator_defines.svh
// assertion macros for the psk pulse-shaping modulator
`ifndef PSK_PULSE_SHAPING_MODULATOR_DEFINES_SVH
`define PSK_PULSE_SHAPING_MODULATOR_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define PSM_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define PSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/psm_pkg.sv
// shared types, constants and command structs of the psk pulse-shaping modulator
package psm_pkg;

    localparam int DEF_MAX_SPS  = 16;
    localparam int DEF_MAX_TAPS = 8;
    localparam int SAMPLE_WIDTH = 16;

    localparam int TAP_W   = 16;
    localparam int PT_W    = 16;
    localparam int PHASE_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // quarter wave and sine polynomial coefficients
    localparam int QUARTER = 16384;
    localparam int SIN_A   = 102943;
    localparam int SIN_B   = 42047;
    localparam int SIN_C   = 4640;

    // register reset values
    localparam logic [4:0]  RST_SPS    = 5'd4;
    localparam logic [3:0]  RST_ORDER  = 4'd2;
    localparam logic [15:0] RST_OFFSET = 16'd0;
    localparam logic [3:0]  RST_TAPS   = 4'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPS    = 3'd0,
        CFG_ORDER  = 3'd1,
        CFG_OFFSET = 3'd2,
        CFG_TAPS   = 3'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        SS_NONE   = 3'd0,
        SS_SQUARE = 3'd1,
        SS_POLY_A = 3'd2,
        SS_POLY_B = 3'd3,
        SS_FINAL  = 3'd4
    } t_sine_step;

    typedef struct packed {
        logic              kind;
        logic [3:0]        tap_branch;
        logic [2:0]        tap_position;
        logic signed [15:0] tap_value;
        logic [7:0]        symbol_index;
    } t_in_word;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample_i;
        logic signed [SAMPLE_WIDTH-1:0] sample_q;
        logic                           last_sample;
    } t_out_word;

    typedef struct packed {
        logic       clr_wr;
        logic       tap_wr;
        logic       sym_load;
        t_sine_step sine_step;
        logic       push;
        logic       mac_issue;
        logic       mac_first;
        logic       out_load;
        logic       out_last;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

### rtl/psm_ctrl.sv
// sequencer for tap memory clearing, sine steps and the per-branch mac walk
module psm_ctrl
    import psm_pkg::*;
#(
    parameter int MAX_SPS  = DEF_MAX_SPS,
    parameter int MAX_TAPS = DEF_MAX_TAPS,
    localparam int BW = (MAX_SPS > 1) ? $clog2(MAX_SPS) : 1,
    localparam int KW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1,
    localparam int AW = BW + KW,
    localparam int SW = $clog2(MAX_SPS + 1),
    localparam int TW = $clog2(MAX_TAPS + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_kind,
    input  logic [SW-1:0] i_sps,
    input  logic [TW-1:0] i_ntaps,
    input  t_dp_status    i_status,
    output logic          o_in_stall,
    output t_dp_cmd       o_cmd,
    output logic [BW-1:0] o_branch,
    output logic [KW-1:0] o_tap_idx,
    output logic [AW-1:0] o_clr_addr
);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_SINE  = 7'b0000100,
        S_PUSH  = 7'b0001000,
        S_MAC   = 7'b0010000,
        S_DRAIN = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state        r_state, n_state;
    t_sine_step    r_step, n_step;
    logic [AW-1:0] r_clr_addr, n_clr_addr;
    logic [BW-1:0] r_b, n_b;
    logic [KW-1:0] r_k, n_k;
    logic          r_drain, n_drain;
    logic          last_k;
    logic          last_b;

    assign last_k = (32'(r_k) + 32'd1) == 32'(i_ntaps);
    assign last_b = (32'(r_b) + 32'd1) == 32'(i_sps);

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_clr_addr = r_clr_addr;
        n_b        = r_b;
        n_k        = r_k;
        n_drain    = r_drain;
        o_cmd      = '0;
        o_cmd.sine_step = SS_NONE;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                n_clr_addr   = r_clr_addr + AW'(1);
                if (&r_clr_addr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_kind) begin
                        o_cmd.sym_load = 1'b1;
                        n_step         = SS_SQUARE;
                        n_state        = S_SINE;
                    end else begin
                        o_cmd.tap_wr = 1'b1;
                    end
                end
            end
            S_SINE: begin
                o_cmd.sine_step = r_step;
                case (r_step)
                    SS_SQUARE: n_step = SS_POLY_A;
                    SS_POLY_A: n_step = SS_POLY_B;
                    SS_POLY_B: n_step = SS_FINAL;
                    default: begin
                        n_step  = SS_NONE;
                        n_state = S_PUSH;
                    end
                endcase
            end
            S_PUSH: begin
                o_cmd.push = 1'b1;
                n_b        = '0;
                n_k        = '0;
                n_state    = S_MAC;
            end
            S_MAC: begin
                o_cmd.mac_issue = 1'b1;
                o_cmd.mac_first = (r_k == '0);
                if (last_k) begin
                    n_k     = '0;
                    n_drain = 1'b0;
                    n_state = S_DRAIN;
                end else begin
                    n_k = r_k + KW'(1);
                end
            end
            S_DRAIN: begin
                n_drain = 1'b1;
                if (r_drain) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_last = last_b;
                    if (last_b) begin
                        n_state = S_IDLE;
                    end else begin
                        n_b     = r_b + BW'(1);
                        n_state = S_MAC;
                    end
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_step     <= SS_NONE;
            r_clr_addr <= '0;
            r_b        <= '0;
            r_k        <= '0;
            r_drain    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_step     <= n_step;
            r_clr_addr <= n_clr_addr;
            r_b        <= n_b;
            r_k        <= n_k;
            r_drain    <= n_drain;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_branch   = r_b;
    assign o_tap_idx  = r_k;
    assign o_clr_addr = r_clr_addr;

`include "psk_pulse_shaping_modulator_defines.svh"

    `PSM_ASSERT_SAME(a_load_only_free, i_clk, i_rst_n, o_cmd.out_load, i_status.out_free, "output loaded while occupied")
    `PSM_ASSERT_SAME(a_tap_in_range, i_clk, i_rst_n, o_cmd.mac_issue, (32'(r_k) < 32'(i_ntaps)), "tap index past branch length")
    `PSM_ASSERT_NEXT(a_push_then_first, i_clk, i_rst_n, o_cmd.push, (o_cmd.mac_issue && o_cmd.mac_first), "mac walk does not start at tap zero")

endmodule

### rtl/psm_datapath.sv
// constellation sine unit, tap memory, symbol history, mac lane and output register
module psm_datapath
    import psm_pkg::*;
#(
    parameter int MAX_SPS  = DEF_MAX_SPS,
    parameter int MAX_TAPS = DEF_MAX_TAPS,
    localparam int BW = (MAX_SPS > 1) ? $clog2(MAX_SPS) : 1,
    localparam int KW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1,
    localparam int AW = BW + KW,
    localparam int ACC_W = 2 * TAP_W + KW + 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    input  logic [BW-1:0]      i_branch,
    input  logic [KW-1:0]      i_tap_idx,
    input  logic [AW-1:0]      i_clr_addr,
    input  t_in_word           i_in_word,
    input  logic [3:0]         i_order_lg,
    input  logic [PHASE_W-1:0] i_phase_offset,
    input  logic               i_out_stall,
    output t_dp_status         o_status,
    output logic               o_out_valid,
    output t_out_word          o_out_word
);

    localparam logic signed [ACC_W-1:0] SAT_MAX =
        ACC_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - ACC_W'(64'sd1);
    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(64'sd8192);

    // symbol to phase
    logic [7:0]         idx_mask;
    logic [7:0]         sym_idx;
    logic [PHASE_W-1:0] sym_phase;
    logic [PHASE_W-1:0] lane_ph [2];
    logic [14:0]        lane_x [2];

    // sine lanes, lane 0 cosine, lane 1 sine
    logic [16:0]            r_z [2];
    logic                   r_neg [2];
    logic [16:0]            r_z2 [2];
    logic [16:0]            r_t [2];
    logic signed [PT_W-1:0] r_pt [2];
    logic [16:0]            mul_a [2];
    logic [16:0]            mul_b [2];
    logic [33:0]            mul_p [2];
    logic [16:0]            fin_s [2];
    logic [16:0]            fin_r [2];
    logic [16:0]            fin_c [2];
    logic signed [PT_W-1:0] fin_pt [2];

    // tap memory and mac lane
    logic signed [TAP_W-1:0] r_taps [2**AW];
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic signed [TAP_W-1:0] wr_data;
    logic [31:0]             br_ext;
    logic [31:0]             pos_ext;
    logic                    tap_ok;

    logic signed [PT_W-1:0]  r_hist_i [MAX_TAPS];
    logic signed [PT_W-1:0]  r_hist_q [MAX_TAPS];
    logic signed [TAP_W-1:0] r_tap_rd;
    logic signed [PT_W-1:0]  r_h_i, r_h_q;
    logic                    r_v1, r_first1, r_v2, r_first2;
    logic signed [TAP_W+PT_W-1:0] r_prod_i, r_prod_q;
    logic signed [ACC_W-1:0] r_acc_i, r_acc_q;
    logic signed [ACC_W-1:0] rnd_i, rnd_q;
    logic signed [ACC_W-1:0] sat_i, sat_q;

    t_out_word r_out;
    logic      r_out_valid;

    always_comb begin
        idx_mask  = 8'((9'd1 << i_order_lg) - 9'd1);
        sym_idx   = i_in_word.symbol_index & idx_mask;
        sym_phase = 16'({8'd0, sym_idx} << (5'd16 - 5'(i_order_lg))) + i_phase_offset;
        lane_ph[0] = sym_phase + 16'(QUARTER);
        lane_ph[1] = sym_phase;
        for (int ln = 0; ln < 2; ln++) begin
            lane_x[ln] = {1'b0, lane_ph[ln][13:0]};
            if (lane_ph[ln][14]) begin
                lane_x[ln] = 15'(QUARTER) - lane_x[ln];
            end
        end
    end

    // one shared multiplier per lane, operands picked by the step
    always_comb begin
        for (int ln = 0; ln < 2; ln++) begin
            mul_a[ln] = r_t[ln];
            mul_b[ln] = r_z[ln];
            unique case (i_cmd.sine_step)
                SS_SQUARE: begin
                    mul_a[ln] = r_z[ln];
                    mul_b[ln] = r_z[ln];
                end
                SS_POLY_A: begin
                    mul_a[ln] = 17'(SIN_C);
                    mul_b[ln] = r_z2[ln];
                end
                SS_POLY_B: begin
                    mul_a[ln] = r_t[ln];
                    mul_b[ln] = r_z2[ln];
                end
                SS_NONE, SS_FINAL: begin
                    mul_a[ln] = r_t[ln];
                    mul_b[ln] = r_z[ln];
                end
                default: begin
                    mul_a[ln] = r_t[ln];
                    mul_b[ln] = r_z[ln];
                end
            endcase
            mul_p[ln] = 34'(mul_a[ln]) * 34'(mul_b[ln]);
            fin_s[ln] = 17'(mul_p[ln] >> 16);
            fin_r[ln] = (fin_s[ln] + 17'd2) >> 2;
            fin_c[ln] = (fin_r[ln] > 17'(QUARTER)) ? 17'(QUARTER) : fin_r[ln];
            fin_pt[ln] = r_neg[ln] ? -PT_W'(fin_c[ln]) : PT_W'(fin_c[ln]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int ln = 0; ln < 2; ln++) begin
            if (i_cmd.sym_load) begin
                r_z[ln]   <= {lane_x[ln], 2'b00};
                r_neg[ln] <= lane_ph[ln][15];
            end
            unique case (i_cmd.sine_step)
                SS_SQUARE: r_z2[ln] <= 17'(mul_p[ln] >> 16);
                SS_POLY_A: r_t[ln]  <= 17'(SIN_B) - 17'(mul_p[ln] >> 16);
                SS_POLY_B: r_t[ln]  <= 17'(SIN_A) - 17'(mul_p[ln] >> 16);
                SS_FINAL:  r_pt[ln] <= fin_pt[ln];
                SS_NONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    // tap memory write: clearing sweep or an in-range tap load
    always_comb begin
        br_ext  = 32'(i_in_word.tap_branch);
        pos_ext = 32'(i_in_word.tap_position);
        tap_ok  = (br_ext < 32'(MAX_SPS)) && (pos_ext < 32'(MAX_TAPS));
        wr_en   = i_cmd.clr_wr || (i_cmd.tap_wr && tap_ok);
        wr_addr = i_cmd.clr_wr ? i_clr_addr : {br_ext[BW-1:0], pos_ext[KW-1:0]};
        wr_data = i_cmd.clr_wr ? '0 : i_in_word.tap_value;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_taps[wr_addr] <= wr_data;
        end
        if (i_cmd.mac_issue) begin
            r_tap_rd <= r_taps[{i_branch, i_tap_idx}];
        end
    end

    // symbol history, newest at entry zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_TAPS; k++) begin
                r_hist_i[k] <= '0;
                r_hist_q[k] <= '0;
            end
        end else if (i_cmd.push) begin
            for (int k = MAX_TAPS - 1; k > 0; k--) begin
                r_hist_i[k] <= r_hist_i[k-1];
                r_hist_q[k] <= r_hist_q[k-1];
            end
            r_hist_i[0] <= r_pt[0];
            r_hist_q[0] <= r_pt[1];
        end
    end

    // mac lane: read, multiply, accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.mac_issue;
            r_v2 <= r_v1;
        end
        if (i_cmd.mac_issue) begin
            r_h_i <= r_hist_i[i_tap_idx];
            r_h_q <= r_hist_q[i_tap_idx];
        end
        r_first1 <= i_cmd.mac_first;
        r_first2 <= r_first1;
        r_prod_i <= r_tap_rd * r_h_i;
        r_prod_q <= r_tap_rd * r_h_q;
        if (r_v2) begin
            r_acc_i <= r_first2 ? ACC_W'(r_prod_i) : r_acc_i + ACC_W'(r_prod_i);
            r_acc_q <= r_first2 ? ACC_W'(r_prod_q) : r_acc_q + ACC_W'(r_prod_q);
        end
    end

    // round by 14 bits and saturate
    always_comb begin
        rnd_i = (r_acc_i + RND_HALF) >>> 14;
        rnd_q = (r_acc_q + RND_HALF) >>> 14;
        sat_i = (rnd_i > SAT_MAX) ? SAT_MAX : ((rnd_i < SAT_MIN) ? SAT_MIN : rnd_i);
        sat_q = (rnd_q > SAT_MAX) ? SAT_MAX : ((rnd_q < SAT_MIN) ? SAT_MIN : rnd_q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out.sample_i    <= sat_i[SAMPLE_WIDTH-1:0];
            r_out.sample_q    <= sat_q[SAMPLE_WIDTH-1:0];
            r_out.last_sample <= i_cmd.out_last;
        end
    end

    assign o_status.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

`include "psk_pulse_shaping_modulator_defines.svh"

    `PSM_ASSERT_NEXT(a_point_bounded, i_clk, i_rst_n, (i_cmd.sine_step == SS_FINAL), ((r_pt[0] <= 16'sd16384) && (r_pt[0] >= -16'sd16384) && (r_pt[1] <= 16'sd16384) && (r_pt[1] >= -16'sd16384)), "constellation point out of range")

endmodule

### rtl/psk_pulse_shaping_modulator.sv
// top level of the m-psk modulator with polyphase pulse-shaping interpolator
//
// An input word either loads one pulse-shape tap (kind 0) or modulates one
// symbol (kind 1). A tap load gives no output. A symbol is masked to the
// configured order, mapped to a Q1.14 constellation point by a fixed-point
// quarter-wave sine (the accept plus four multiply steps), pushed into the
// symbol history, and then one output word is made per polyphase branch,
// samples_per_symbol words in all, the last flagged. Each output sample walks
// the branch taps through a single mac lane, one tap read from the tap memory
// per cycle, then drains the mac pipeline and waits for a free output
// register to load. The next input word is taken once the last sample of a
// symbol is loaded into the output register. After reset the tap memory is
// swept to zero, one entry a cycle, over all 2**(clog2(MAX_SPS) +
// clog2(MAX_TAPS_PER_BRANCH)) entries (128 at the default sizes), during
// which no input word is taken; configuration writes are taken at any time
// but are meant to land while the block is idle.
// Register indexes: 0 samples_per_symbol, 1 order_log2, 2 phase_offset,
// 3 branch_taps; out-of-range values are clamped on use.
module psk_pulse_shaping_modulator
    import psm_pkg::*;
#(
    parameter int MAX_SPS             = DEF_MAX_SPS,
    parameter int MAX_TAPS_PER_BRANCH = DEF_MAX_TAPS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input words
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_word              i_in_word,
    // output words
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_word             o_out_word,
    // register writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int BW = (MAX_SPS > 1) ? $clog2(MAX_SPS) : 1;
    localparam int KW = (MAX_TAPS_PER_BRANCH > 1) ? $clog2(MAX_TAPS_PER_BRANCH) : 1;
    localparam int AW = BW + KW;
    localparam int SW = $clog2(MAX_SPS + 1);
    localparam int TW = $clog2(MAX_TAPS_PER_BRANCH + 1);

    // raw register bits, clamped where they are used
    logic [4:0]  r_sps_raw;
    logic [3:0]  r_order_raw;
    logic [15:0] r_offset;
    logic [3:0]  r_taps_raw;

    logic [SW-1:0] sps_eff;
    logic [TW-1:0] ntaps_eff;
    logic [3:0]    order_eff;

    t_dp_cmd       cmd;
    t_dp_status    status;
    logic [BW-1:0] branch;
    logic [KW-1:0] tap_idx;
    logic [AW-1:0] clr_addr;

    // the register port never back-pressures
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sps_raw   <= RST_SPS;
            r_order_raw <= RST_ORDER;
            r_offset    <= RST_OFFSET;
            r_taps_raw  <= RST_TAPS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_SPS:    r_sps_raw   <= i_cfg_data[4:0];
                CFG_ORDER:  r_order_raw <= i_cfg_data[3:0];
                CFG_OFFSET: r_offset    <= i_cfg_data[15:0];
                CFG_TAPS:   r_taps_raw  <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    // zero acts as one, oversize acts as the maximum
    always_comb begin
        if (r_sps_raw == '0) begin
            sps_eff = SW'(1);
        end else if (32'(r_sps_raw) > 32'(MAX_SPS)) begin
            sps_eff = SW'(MAX_SPS);
        end else begin
            sps_eff = SW'(r_sps_raw);
        end
        if (r_taps_raw == '0) begin
            ntaps_eff = TW'(1);
        end else if (32'(r_taps_raw) > 32'(MAX_TAPS_PER_BRANCH)) begin
            ntaps_eff = TW'(MAX_TAPS_PER_BRANCH);
        end else begin
            ntaps_eff = TW'(r_taps_raw);
        end
        if (r_order_raw == '0) begin
            order_eff = 4'd1;
        end else if (r_order_raw > 4'd8) begin
            order_eff = 4'd8;
        end else begin
            order_eff = r_order_raw;
        end
    end

    psm_ctrl #(
        .MAX_SPS  (MAX_SPS),
        .MAX_TAPS (MAX_TAPS_PER_BRANCH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_kind  (i_in_word.kind),
        .i_sps      (sps_eff),
        .i_ntaps    (ntaps_eff),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .o_branch   (branch),
        .o_tap_idx  (tap_idx),
        .o_clr_addr (clr_addr)
    );

    psm_datapath #(
        .MAX_SPS  (MAX_SPS),
        .MAX_TAPS (MAX_TAPS_PER_BRANCH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_branch       (branch),
        .i_tap_idx      (tap_idx),
        .i_clr_addr     (clr_addr),
        .i_in_word      (i_in_word),
        .i_order_lg     (order_eff),
        .i_phase_offset (r_offset),
        .i_out_stall    (i_out_stall),
        .o_status       (status),
        .o_out_valid    (o_out_valid),
        .o_out_word     (o_out_word)
    );

endmodule

### tb/sv/psk_pulse_shaping_modulator_checker.sv
// word kinds and the order limit shared by the testbench and the output checker of the psk modulator
package psm_tb_pkg;

    localparam logic KIND_TAP    = 1'b0;
    localparam logic KIND_SYMBOL = 1'b1;

    localparam int ORDER_LOG2_MAX = 8;

endpackage

module psk_pulse_shaping_modulator_checker
    import psm_pkg::*;
    import psm_tb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  t_in_word              i_in_word,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  t_out_word             i_out_word,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROUND_SHIFT = 14;

    logic signed [TAP_W-1:0] tap_mem [DEF_MAX_SPS][DEF_MAX_TAPS];
    int                      hist_i [DEF_MAX_TAPS];
    int                      hist_q [DEF_MAX_TAPS];
    logic [4:0]              sps_reg;
    logic [3:0]              order_reg;
    logic [15:0]             offset_reg;
    logic [3:0]              taps_reg;

    t_out_word expected_samples [$];
    int        fails  = 0;
    int        checks = 0;
    int        pend   = 0;

    assign o_fail_count = fails;
    assign o_pending    = pend;
    assign o_checked    = checks;

    // sine on the first quarter, q1.14 result
    function automatic int unsigned quarter_wave(input int unsigned x);
        longint unsigned z, z2, t, s;
        z  = longint'(x) << 2;
        z2 = (z * z) >> 16;
        t  = (longint'(SIN_C) * z2) >> 16;
        t  = longint'(SIN_B) - t;
        t  = (t * z2) >> 16;
        t  = longint'(SIN_A) - t;
        s  = (t * z) >> 16;
        s  = (s + 2) >> 2;
        if (s > QUARTER) begin
            s = QUARTER;
        end
        return int'(s);
    endfunction

    function automatic int wave_sine(input int unsigned phase);
        int unsigned p, x;
        int          v;
        p = phase & 32'hFFFF;
        x = p & (QUARTER - 1);
        if (p[14]) begin
            x = QUARTER - x;
        end
        v = int'(quarter_wave(x));
        return p[15] ? -v : v;
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] round_sat(input longint acc);
        longint r, top_v;
        top_v = (longint'(1) << (SAMPLE_WIDTH - 1)) - 1;
        r     = (acc + (longint'(1) << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
        if (r > top_v) begin
            r = top_v;
        end
        if (r < -top_v - 1) begin
            r = -top_v - 1;
        end
        return r[SAMPLE_WIDTH-1:0];
    endfunction

    task automatic modulate_symbol(input logic [7:0] raw);
        int unsigned sps, lg, ntaps, idx, phase;
        longint      acc_i, acc_q;
        t_out_word   s;
        sps   = (sps_reg == 0) ? 1 : ((sps_reg > DEF_MAX_SPS) ? DEF_MAX_SPS : sps_reg);
        lg    = (order_reg == 0) ? 1 :
                ((order_reg > ORDER_LOG2_MAX) ? ORDER_LOG2_MAX : order_reg);
        ntaps = (taps_reg == 0) ? 1 : ((taps_reg > DEF_MAX_TAPS) ? DEF_MAX_TAPS : taps_reg);
        idx   = raw & ((1 << lg) - 1);
        phase = ((idx << (PHASE_W - lg)) + offset_reg) & 32'hFFFF;
        for (int k = DEF_MAX_TAPS - 1; k > 0; k--) begin
            hist_i[k] = hist_i[k-1];
            hist_q[k] = hist_q[k-1];
        end
        hist_i[0] = wave_sine(phase + QUARTER);
        hist_q[0] = wave_sine(phase);
        for (int b = 0; b < sps; b++) begin
            acc_i = 0;
            acc_q = 0;
            for (int k = 0; k < ntaps; k++) begin
                acc_i += longint'(tap_mem[b][k]) * hist_i[k];
                acc_q += longint'(tap_mem[b][k]) * hist_q[k];
            end
            s.sample_i    = round_sat(acc_i);
            s.sample_q    = round_sat(acc_q);
            s.last_sample = (b == sps - 1);
            expected_samples.insert(expected_samples.size(), s);
        end
    endtask

    always @(posedge i_clk) begin : track
        t_out_word want;
        if (!i_rst_n) begin
            for (int b = 0; b < DEF_MAX_SPS; b++) begin
                for (int k = 0; k < DEF_MAX_TAPS; k++) begin
                    tap_mem[b][k] = '0;
                end
            end
            for (int k = 0; k < DEF_MAX_TAPS; k++) begin
                hist_i[k] = 0;
                hist_q[k] = 0;
            end
            sps_reg    = RST_SPS;
            order_reg  = RST_ORDER;
            offset_reg = RST_OFFSET;
            taps_reg   = RST_TAPS;
            expected_samples.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_samples.size() == 0) begin
                    fails++;
                    $error("output word with no sample expected: i %0d q %0d last %0b",
                           i_out_word.sample_i, i_out_word.sample_q, i_out_word.last_sample);
                end else begin
                    want = expected_samples.pop_front();
                    checks++;
                    if (i_out_word.sample_i !== want.sample_i) begin
                        fails++;
                        $error("sample_i mismatch: expected %0d, actual %0d",
                               want.sample_i, i_out_word.sample_i);
                    end
                    if (i_out_word.sample_q !== want.sample_q) begin
                        fails++;
                        $error("sample_q mismatch: expected %0d, actual %0d",
                               want.sample_q, i_out_word.sample_q);
                    end
                    if (i_out_word.last_sample !== want.last_sample) begin
                        fails++;
                        $error("last_sample mismatch: expected %0b, actual %0b",
                               want.last_sample, i_out_word.last_sample);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_SPS:    sps_reg    = i_cfg_data[4:0];
                    CFG_ORDER:  order_reg  = i_cfg_data[3:0];
                    CFG_OFFSET: offset_reg = i_cfg_data[15:0];
                    CFG_TAPS:   taps_reg   = i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                // branch and position fields always fit the store
                if (i_in_word.kind == KIND_TAP) begin
                    tap_mem[i_in_word.tap_branch][i_in_word.tap_position] = i_in_word.tap_value;
                end else begin
                    modulate_symbol(i_in_word.symbol_index);
                end
            end
        end
        pend = expected_samples.size();
    end

endmodule

### tb/sv/psk_pulse_shaping_modulator_tb.sv
// testbench top of the psk pulse-shaping modulator: stimulus, receiver and verdict
module psk_pulse_shaping_modulator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import psm_pkg::*;
    import psm_tb_pkg::*;

    localparam int RESET_CYCLES  = 12;
    localparam int ITEM_TARGET   = 430;
    // from here on neither side idles
    localparam int CALM_FROM     = 390;
    // the receiver hold-off starts once this many words went in
    localparam int PRESSURE_AT   = 140;
    localparam int HOLD_CYCLES   = 300;
    // a short pause covers a trailing tap load
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_CYCLES  = 64;
    // well above the clear sweep, the slowest symbol and the receiver hold-off
    localparam int IDLE_LIMIT    = 4000;

    logic                  i_clk;
    logic                  i_rst_n   = 1'b0;
    logic                  in_valid  = 1'b0;
    t_in_word              in_word   = '0;
    logic                  out_stall = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word out_word;
    logic      o_cfg_ready;

    int fail_count;
    int pending;
    int checked;

    // stimulus counters and flags; n_items and calm are also read by the receiver
    int n_items    = 0;
    int n_symbols  = 0;
    int n_taps     = 0;
    int n_writes   = 0;
    int n_settings = 0;
    int gap_odds   = 3;
    bit calm       = 1'b0;

    psk_pulse_shaping_modulator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    psk_pulse_shaping_modulator_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_word    (in_word),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // mostly moderate taps so sums stay in range, a quarter full range to hit saturation
    function automatic logic [15:0] rand_tap();
        if ($urandom_range(0, 3) == 0) begin
            return 16'($urandom);
        end
        return 16'($urandom_range(0, 8191) - 32'd4096);
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance;
    // valid stays high so a following word goes out back to back
    task automatic push_word(input t_in_word w);
        int gap;
        if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            gap = $urandom_range(1, 13);
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        n_items++;
    endtask

    // unused fields carry random bits
    task automatic send_tap(input int branch, input int position, input logic [15:0] value);
        t_in_word w;
        w.kind         = KIND_TAP;
        w.tap_branch   = branch[3:0];
        w.tap_position = position[2:0];
        w.tap_value    = value;
        w.symbol_index = 8'($urandom);
        push_word(w);
        n_taps++;
    endtask

    task automatic send_symbol(input logic [7:0] index);
        t_in_word w;
        w.kind         = KIND_SYMBOL;
        w.tap_branch   = 4'($urandom);
        w.tap_position = 3'($urandom);
        w.tap_value    = 16'($urandom);
        w.symbol_index = index;
        push_word(w);
        n_symbols++;
    endtask

    // stop offering, wait for every expected sample, then let a trailing tap load land
    task automatic settle_block();
        in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
        @(negedge i_clk);
        n_writes++;
    endtask

    task automatic apply_setting(input logic [15:0] sps, input logic [15:0] order,
                                 input logic [15:0] offset, input logic [15:0] taps);
        write_reg(CFG_SPS, sps);
        write_reg(CFG_ORDER, order);
        write_reg(CFG_OFFSET, offset);
        write_reg(CFG_TAPS, taps);
        n_settings++;
    endtask

    // receiver: random stall bursts, long open stretches, one long hold-off
    initial begin : receiver
        bit held;
        int len;
        held = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (!held && n_items >= PRESSURE_AT && in_valid) begin
                // block fills up and stalls its input while the sender keeps offering
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                held = 1'b1;
            end else if (calm) begin
                out_stall <= 1'b0;
                @(negedge i_clk);
            end else begin
                case ($urandom_range(0, 3))
                    0: begin
                        len = $urandom_range(1, 13);
                        out_stall <= 1'b1;
                    end
                    1: begin
                        len = $urandom_range(20, 60);
                        out_stall <= 1'b0;
                    end
                    default: begin
                        len = $urandom_range(1, 13);
                        out_stall <= 1'b0;
                    end
                endcase
                repeat (len) @(negedge i_clk);
            end
        end
    end

    // ends the run when nothing moves on any channel for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall) ||
                (cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
        $display("psk_pulse_shaping_modulator regression: fail");
        $finish;
    end

    initial begin : stimulus
        logic [15:0] sps_val, order_val, taps_val, junk;
        int          eff_sps, eff_taps, body_len, spare;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset setting: tap extremes, saturation in branch 0, every symbol of qpsk
        send_tap(0, 0, 16'h7FFF);
        send_tap(0, 1, 16'h7FFF);
        send_tap(1, 0, 16'h8000);
        send_tap(2, 1, 16'h2000);
        send_tap(3, 7, 16'hE000);
        send_tap(15, 7, 16'hFFFF);
        send_symbol(8'h00);
        send_symbol(8'h01);
        send_symbol(8'h02);
        send_symbol(8'h03);
        send_symbol(8'hFF);
        send_symbol(8'hAA);

        // upper extremes of every register
        settle_block();
        apply_setting(16'(DEF_MAX_SPS), 16'(ORDER_LOG2_MAX), 16'hFFFF, 16'(DEF_MAX_TAPS));
        send_tap(15, 0, 16'h4000);
        send_symbol(8'h00);
        send_symbol(8'hFF);
        send_symbol(8'h55);

        // zero values act as one
        settle_block();
        apply_setting(16'h0000, 16'h0000, 16'h8000, 16'h0000);
        send_symbol(8'h01);
        send_symbol(8'hFE);

        // oversize values clamp to the maximum, junk in the upper data bits
        settle_block();
        apply_setting(16'hFFFF, 16'hFFFF, 16'h4000, 16'hFFFF);
        send_symbol(8'h03);
        send_symbol(8'h80);

        // lower extremes, plus writes to indexes that hold no register
        settle_block();
        apply_setting(16'd1, 16'd1, 16'h0000, 16'd1);
        for (int u = int'(CFG_TAPS) + 1; u < (1 << CFG_IDX_W); u++) begin
            write_reg(u[CFG_IDX_W-1:0], 16'hFFFF);
        end
        send_symbol(8'hFF);
        send_tap(0, 0, 16'h1000);
        send_symbol(8'h00);

        // random phases: new setting, usually a full pulse shape, then a mix of words
        while (n_items < ITEM_TARGET) begin
            if (n_items >= CALM_FROM) begin
                calm = 1'b1;
            end
            settle_block();

            case ($urandom_range(0, 9))
                0:       sps_val = 16'd0;
                1:       sps_val = 16'($urandom_range(DEF_MAX_SPS + 1, 31));
                2:       sps_val = 16'(DEF_MAX_SPS);
                default: sps_val = 16'($urandom_range(1, 6));
            endcase
            case ($urandom_range(0, 9))
                0:       order_val = 16'd0;
                1:       order_val = 16'($urandom_range(ORDER_LOG2_MAX + 1, 15));
                default: order_val = 16'($urandom_range(1, ORDER_LOG2_MAX));
            endcase
            case ($urandom_range(0, 9))
                0:       taps_val = 16'd0;
                1:       taps_val = 16'($urandom_range(DEF_MAX_TAPS + 1, 15));
                default: taps_val = 16'($urandom_range(1, DEF_MAX_TAPS));
            endcase
            eff_sps  = (sps_val == 0) ? 1 : ((sps_val > DEF_MAX_SPS) ? DEF_MAX_SPS : sps_val);
            eff_taps = (taps_val == 0) ? 1 :
                       ((taps_val > DEF_MAX_TAPS) ? DEF_MAX_TAPS : taps_val);
            junk = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'h0000;
            apply_setting({junk[15:5], sps_val[4:0]}, {junk[15:4], order_val[3:0]},
                          16'($urandom), {junk[15:4], taps_val[3:0]});
            if ($urandom_range(0, 3) == 0) begin
                spare = $urandom_range(int'(CFG_TAPS) + 1, (1 << CFG_IDX_W) - 1);
                write_reg(spare[CFG_IDX_W-1:0], 16'($urandom));
            end

            // some phases run with no sender idling at all
            gap_odds = ($urandom_range(0, 3) == 0) ? 0 : 3;

            if (eff_sps * eff_taps <= 24 && $urandom_range(0, 3) != 0) begin
                for (int b = 0; b < eff_sps; b++) begin
                    for (int k = 0; k < eff_taps; k++) begin
                        send_tap(b, k, rand_tap());
                    end
                end
            end

            body_len = $urandom_range(8, 30);
            repeat (body_len) begin
                if ($urandom_range(0, 6) == 0) begin
                    send_tap($urandom_range(0, 15), $urandom_range(0, 7), rand_tap());
                end else begin
                    send_symbol(8'($urandom_range(0, 255)));
                end
            end
        end

        // drain
        in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("covered %0d symbols and %0d tap loads under %0d settings (%0d writes)",
                 n_symbols, n_taps, n_settings, n_writes);
        $display("checked %0d samples, clamped and extreme registers, %0d-cycle output hold-off",
                 checked, HOLD_CYCLES);
        if (fail_count == 0 && pending == 0) begin
            $display("psk_pulse_shaping_modulator regression: pass");
        end else begin
            $display("psk_pulse_shaping_modulator regression: fail");
        end
        $finish;
    end

endmodule

### psk_pulse_shaping_modulator.f
+incdir+rtl
rtl/psm_pkg.sv
rtl/psm_ctrl.sv
rtl/psm_datapath.sv
rtl/psk_pulse_shaping_modulator.sv
tb/sv/psk_pulse_shaping_modulator_checker.sv
tb/sv/psk_pulse_shaping_modulator_tb.sv
